>>> src/atlr_pkg.sv
package atlr_pkg;

	localparam int unsigned ADDR_W = 48;
	localparam int unsigned STEP_W = 4;

	localparam logic [ADDR_W-1:0] PEER_A_RESET = 48'h98D3_3381_1615;
	localparam logic [ADDR_W-1:0] PEER_B_RESET = 48'h98D3_3270_CF48;

	localparam logic CFG_PEER_A = 1'b0;
	localparam logic CFG_PEER_B = 1'b1;

	localparam logic [2:0] PH_CMODE = 3'd0;
	localparam logic [2:0] PH_ROLE  = 3'd1;
	localparam logic [2:0] PH_BIND  = 3'd2;
	localparam logic [2:0] PH_LINK  = 3'd3;
	localparam logic [2:0] PH_MSG   = 3'd4;
	localparam logic [2:0] PH_DISC  = 3'd5;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;

	localparam logic [8*10-1:0] CMODE_STR = "AT+CMODE=0";
	localparam logic [8*9-1:0]  ROLE_STR  = "AT+ROLE=1";
	localparam logic [8*22-1:0] BIND_STR  = "AT+BIND=0000,00,000000";
	localparam logic [8*7-1:0]  DISC_STR  = "AT+DISC";
	localparam logic [8*8-1:0]  LINK_STR  = "AT+LINK=";
	localparam logic [8*4-1:0]  OK_PAT    = {"OK", CHAR_CR, CHAR_LF};
	localparam logic [8*10-1:0] SUCC_PAT  = {":SUCCESS", CHAR_CR, CHAR_LF};
	localparam logic [8*4-1:0]  HOLA_STR  = "HOLA";

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} evt_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       receive_mode;
		logic       key_pin;
		logic [2:0] phase;
		logic       peer_select;
	} res_t;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_TX_EVENT,
		COND_RX_EVENT,
		COND_PHASE_HIGH,
		COND_PHASE_MSG,
		COND_OUT_BUSY
	} cond_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_ACCEPT,
		ACT_READ,
		ACT_TX_CHAR,
		ACT_TX_BAD,
		ACT_MATCH,
		ACT_STORE,
		ACT_EMIT
	} act_t;

	typedef struct packed {
		cond_t cond;
		step_t target;
		act_t  act;
	} ucode_t;

	localparam step_t STEP_IDLE    = 4'd0;
	localparam step_t STEP_TX_TEST = 4'd1;
	localparam step_t STEP_RX_TEST = 4'd2;
	localparam step_t STEP_PASS    = 4'd3;
	localparam step_t STEP_TX      = 4'd4;
	localparam step_t STEP_READ    = 4'd5;
	localparam step_t STEP_TX_CHAR = 4'd6;
	localparam step_t STEP_TX_BAD  = 4'd7;
	localparam step_t STEP_RX      = 4'd8;
	localparam step_t STEP_MATCH   = 4'd9;
	localparam step_t STEP_STORE   = 4'd10;
	localparam step_t STEP_EMIT    = 4'd11;
	localparam step_t STEP_DONE    = 4'd12;

	// A word jumps to its target when its condition holds, otherwise it falls through.
	function automatic ucode_t ucode_rom(step_t s);
		ucode_t w;
		unique case (s)
			STEP_IDLE:    w = '{cond: COND_NO_INPUT,   target: STEP_IDLE,    act: ACT_ACCEPT};
			STEP_TX_TEST: w = '{cond: COND_TX_EVENT,   target: STEP_TX,      act: ACT_NONE};
			STEP_RX_TEST: w = '{cond: COND_RX_EVENT,   target: STEP_RX,      act: ACT_NONE};
			STEP_PASS:    w = '{cond: COND_ALWAYS,     target: STEP_EMIT,    act: ACT_NONE};
			STEP_TX:      w = '{cond: COND_PHASE_HIGH, target: STEP_TX_BAD,  act: ACT_NONE};
			STEP_READ:    w = '{cond: COND_ALWAYS,     target: STEP_TX_CHAR, act: ACT_READ};
			STEP_TX_CHAR: w = '{cond: COND_ALWAYS,     target: STEP_EMIT,    act: ACT_TX_CHAR};
			STEP_TX_BAD:  w = '{cond: COND_ALWAYS,     target: STEP_EMIT,    act: ACT_TX_BAD};
			STEP_RX:      w = '{cond: COND_PHASE_MSG,  target: STEP_STORE,   act: ACT_NONE};
			STEP_MATCH:   w = '{cond: COND_ALWAYS,     target: STEP_EMIT,    act: ACT_MATCH};
			STEP_STORE:   w = '{cond: COND_ALWAYS,     target: STEP_EMIT,    act: ACT_STORE};
			STEP_EMIT:    w = '{cond: COND_OUT_BUSY,   target: STEP_EMIT,    act: ACT_EMIT};
			STEP_DONE:    w = '{cond: COND_ALWAYS,     target: STEP_IDLE,    act: ACT_NONE};
			default:      w = '{cond: COND_ALWAYS,     target: STEP_IDLE,    act: ACT_NONE};
		endcase
		return w;
	endfunction

	// Command length for the fixed-text phases; the message phase is sized by the top level.
	function automatic logic [6:0] cmd_len(logic [2:0] ph);
		logic [6:0] n;
		unique case (ph)
			PH_CMODE: n = 7'd10;
			PH_ROLE:  n = 7'd9;
			PH_BIND:  n = 7'd22;
			PH_LINK:  n = 7'd22;
			default:  n = 7'd7;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] cmd_char(logic [2:0] ph, logic [6:0] pos);
		logic [7:0] c;
		c = 8'h00;
		unique case (ph)
			PH_CMODE: if (pos < 7'd10) c = CMODE_STR[8*(9-int'(pos)) +: 8];
			PH_ROLE:  if (pos < 7'd9)  c = ROLE_STR[8*(8-int'(pos)) +: 8];
			PH_BIND:  if (pos < 7'd22) c = BIND_STR[8*(21-int'(pos)) +: 8];
			default:  if (pos < 7'd7)  c = DISC_STR[8*(6-int'(pos)) +: 8];
		endcase
		return c;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'h0, nib};
		end else begin
			c = 8'h37 + {4'h0, nib};
		end
		return c;
	endfunction

	// Address is printed as 4, 2 and 6 hex digits separated by commas.
	function automatic logic [7:0] link_char(logic [ADDR_W-1:0] addr, logic [6:0] pos);
		logic [6:0] digit;
		logic [7:0] c;
		c = 8'h00;
		if (pos < 7'd8) begin
			c = LINK_STR[8*(7-int'(pos)) +: 8];
		end else if (pos == 7'd12 || pos == 7'd15) begin
			c = CHAR_COMMA;
		end else begin
			if (pos < 7'd12) begin
				digit = pos - 7'd8;
			end else if (pos < 7'd15) begin
				digit = pos - 7'd9;
			end else begin
				digit = pos - 7'd10;
			end
			if (digit <= 7'd11) c = hex_char(addr[4*(11-int'(digit)) +: 4]);
		end
		return c;
	endfunction

	function automatic logic [7:0] ok_char(logic [6:0] pos);
		logic [7:0] c;
		c = 8'h00;
		if (pos < 7'd4) c = OK_PAT[8*(3-int'(pos)) +: 8];
		return c;
	endfunction

	function automatic logic [7:0] succ_char(logic [6:0] pos);
		logic [7:0] c;
		c = 8'h00;
		if (pos < 7'd10) c = SUCC_PAT[8*(9-int'(pos)) +: 8];
		return c;
	endfunction

	// Contents of a buffer entry that has never been written or cleared.
	function automatic logic [7:0] hola_char(logic [6:0] pos);
		logic [7:0] c;
		c = 8'h00;
		if (pos < 7'd4) c = HOLA_STR[8*(3-int'(pos)) +: 8];
		return c;
	endfunction

endpackage

>>> src/atlr_ram.sv
module atlr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

>>> src/at_command_link_relay_core.sv
// A result is offered once its transaction has passed through the microcode steps of the
// sequencer: accept, direction tests, the steps for its action, then emit.
// One transaction at a time: a new one is accepted only after the last result is emitted.
// Reset: sequencer to idle, phase, position, peer and direction cleared, key pin high.
// Each buffer keeps a fill count cleared at reset; entries past it read back as HOLA and
// zeros, or as zeros once the buffer was wiped, so no clearing pass is needed.
module at_command_link_relay_core #(
	parameter int unsigned MSG_LEN = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          evt_valid,
	output logic                          evt_ready,
	input  atlr_pkg::evt_t                evt,
	output logic                          res_valid,
	input  logic                          res_ready,
	output atlr_pkg::res_t                res,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [atlr_pkg::ADDR_W-1:0]   cfg_data
);

	import atlr_pkg::*;

	localparam int unsigned DEPTH = 2 * MSG_LEN;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam logic [6:0] MSG_LEN_W = 7'(MSG_LEN);
	localparam logic [AW-1:0] MSG_BASE = AW'(MSG_LEN);

	step_t             step_q, step_d;
	ucode_t            uc;
	logic              cond_hit;
	logic              out_busy;

	logic [ADDR_W-1:0] peer_a_q, peer_b_q;
	logic [2:0]        phase_q;
	logic [6:0]        pos_q;
	logic              peer_q, recv_q, pin_q;
	logic              txv_q;
	logic [7:0]        txb_q;
	logic              mode_q;
	logic [7:0]        rxb_q;
	logic [6:0]        fill_a_q, fill_b_q;
	logic [1:0]        zero_q;
	logic              res_valid_q;
	res_t              res_q;

	logic [6:0]        cmd_n;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic              rd_hit;
	logic [7:0]        mem_rdata;
	logic [7:0]        msg_char, tx_char;
	logic [6:0]        pat_n;
	logic [7:0]        pat_c;
	logic              pat_use, pat_hit, pat_last;
	logic              store_end;
	logic              mem_we, mem_re;

	assign uc = ucode_rom(step_q);
	assign out_busy = res_valid_q && !res_ready;
	assign evt_ready = (uc.act == ACT_ACCEPT);

	always_comb begin
		unique case (uc.cond)
			COND_ALWAYS:     cond_hit = 1'b1;
			COND_NO_INPUT:   cond_hit = !evt_valid;
			COND_TX_EVENT:   cond_hit = !mode_q && !recv_q;
			COND_RX_EVENT:   cond_hit = mode_q && recv_q;
			COND_PHASE_HIGH: cond_hit = (phase_q > PH_DISC);
			COND_PHASE_MSG:  cond_hit = (phase_q == PH_MSG);
			COND_OUT_BUSY:   cond_hit = out_busy;
			default:         cond_hit = 1'b1;
		endcase
		step_d = cond_hit ? uc.target : step_t'(step_q + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// Message reads address the buffer of the current peer; replies go to the other one.
	assign rd_addr = peer_q ? MSG_BASE + AW'(pos_q) : AW'(pos_q);
	assign wr_addr = peer_q ? AW'(pos_q) : MSG_BASE + AW'(pos_q);

	assign cmd_n = (phase_q == PH_MSG) ? MSG_LEN_W : cmd_len(phase_q);

	// An entry that was never written shows HOLA, or zero once its buffer was cleared.
	assign rd_hit = (pos_q < MSG_LEN_W) && (pos_q < (peer_q ? fill_b_q : fill_a_q));
	assign msg_char = rd_hit ? mem_rdata : (zero_q[peer_q] ? 8'h00 : hola_char(pos_q));

	always_comb begin
		unique case (phase_q)
			PH_MSG:  tx_char = msg_char;
			PH_LINK: tx_char = link_char(peer_q ? peer_b_q : peer_a_q, pos_q);
			default: tx_char = cmd_char(phase_q, pos_q);
		endcase
	end

	assign pat_use  = (phase_q <= PH_LINK) || (phase_q == PH_DISC);
	assign pat_n    = (phase_q == PH_DISC) ? 7'd10 : 7'd4;
	assign pat_c    = (phase_q == PH_DISC) ? succ_char(pos_q) : ok_char(pos_q);
	assign pat_hit  = pat_use && (pos_q < pat_n) && (rxb_q == pat_c);
	assign pat_last = (pos_q == pat_n - 7'd1);

	assign store_end = (rxb_q == CHAR_LF) || (pos_q >= MSG_LEN_W);
	assign mem_we = (uc.act == ACT_STORE) && !store_end;
	assign mem_re = (uc.act == ACT_READ);

	atlr_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_addr),
		.wdata (rxb_q),
		.re    (mem_re),
		.raddr (rd_addr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_a_q    <= PEER_A_RESET;
			peer_b_q    <= PEER_B_RESET;
			phase_q     <= PH_CMODE;
			pos_q       <= '0;
			peer_q      <= 1'b0;
			recv_q      <= 1'b0;
			pin_q       <= 1'b1;
			txv_q       <= 1'b0;
			fill_a_q    <= '0;
			fill_b_q    <= '0;
			zero_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PEER_A: peer_a_q <= cfg_data;
					CFG_PEER_B: peer_b_q <= cfg_data;
					default:    peer_a_q <= cfg_data;
				endcase
			end
			// A stalled result stays; the emit step only runs once the output is free.
			res_valid_q <= out_busy || (uc.act == ACT_EMIT);
			unique case (uc.act)
				ACT_ACCEPT: begin
					if (evt_valid) txv_q <= 1'b0;
				end
				ACT_TX_CHAR: begin
					if (phase_q == PH_MSG) pin_q <= 1'b0;
					if (phase_q == PH_DISC) pin_q <= 1'b1;
					if (pos_q <= cmd_n + 7'd1) begin
						txv_q <= 1'b1;
						pos_q <= pos_q + 7'd1;
					end else begin
						pos_q  <= '0;
						recv_q <= 1'b1;
					end
				end
				ACT_TX_BAD: begin
					txv_q  <= 1'b1;
					recv_q <= 1'b1;
				end
				ACT_MATCH: begin
					if (pat_hit) begin
						if (pat_last) begin
							pos_q  <= '0;
							recv_q <= 1'b0;
							if (phase_q == PH_DISC) begin
								phase_q <= PH_LINK;
								peer_q  <= ~peer_q;
							end else begin
								phase_q <= phase_q + 3'd1;
							end
						end else begin
							pos_q <= pos_q + 7'd1;
						end
					end
				end
				ACT_STORE: begin
					if (store_end) begin
						pos_q   <= '0;
						phase_q <= PH_DISC;
						recv_q  <= 1'b0;
					end else begin
						pos_q <= pos_q + 7'd1;
					end
					// Every reply byte wipes the buffer that was just sent.
					if (peer_q) begin
						fill_b_q <= '0;
						if (!store_end) fill_a_q <= pos_q + 7'd1;
					end else begin
						fill_a_q <= '0;
						if (!store_end) fill_b_q <= pos_q + 7'd1;
					end
					zero_q[peer_q] <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (uc.act)
			ACT_ACCEPT: begin
				if (evt_valid) begin
					mode_q <= evt.mode;
					rxb_q  <= evt.rx_byte;
					txb_q  <= 8'h00;
				end
			end
			ACT_TX_CHAR: begin
				if (pos_q < cmd_n) begin
					txb_q <= tx_char;
				end else if (pos_q == cmd_n) begin
					txb_q <= CHAR_CR;
				end else if (pos_q == cmd_n + 7'd1) begin
					txb_q <= CHAR_LF;
				end
			end
			ACT_TX_BAD: txb_q <= 8'h00;
			ACT_EMIT: begin
				if (!out_busy) begin
					res_q.tx_valid     <= txv_q;
					res_q.tx_byte      <= txb_q;
					res_q.receive_mode <= recv_q;
					res_q.key_pin      <= pin_q;
					res_q.phase        <= phase_q;
					res_q.peer_select  <= peer_q;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

>>> src/atlr_checker.sv
module atlr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        evt_valid,
	input logic                        evt_ready,
	input atlr_pkg::evt_t              evt,
	input logic                        res_valid,
	input logic                        res_ready,
	input atlr_pkg::res_t              res,
	input logic                        cfg_we,
	input logic                        cfg_index,
	input logic [atlr_pkg::ADDR_W-1:0] cfg_data
);

	import atlr_pkg::*;

	// A stalled result keeps its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// One event at a time: the sequencer leaves its accept step after a transaction.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready |=> !evt_ready)
		else $error("second event accepted back to back");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.phase <= PH_DISC)
		else $error("phase out of range");

	a_quiet_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.tx_valid |-> res.tx_byte == 8'h00)
		else $error("byte set without transmit");

endmodule

bind at_command_link_relay_core atlr_checker u_atlr_checker (.*);

>>> verif/tb_at_command_link_relay_core.sv
`timescale 1ns / 100ps

module tb_at_command_link_relay_core;

	import atlr_pkg::*;

	localparam int unsigned MSG_LEN = 64;
	localparam int unsigned WORK_ITEMS = 830;
	localparam int unsigned QUIET_FROM = 710;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned CYCLE_LIMIT = 500_000;

	localparam logic [8*10-1:0] TXT_CMODE = "AT+CMODE=0";
	localparam logic [8*9-1:0]  TXT_ROLE  = "AT+ROLE=1";
	localparam logic [8*22-1:0] TXT_BIND  = "AT+BIND=0000,00,000000";
	localparam logic [8*7-1:0]  TXT_DISC  = "AT+DISC";
	localparam logic [8*8-1:0]  TXT_LINK  = "AT+LINK=";
	localparam logic [8*16-1:0] TXT_HEX   = "0123456789ABCDEF";
	localparam logic [8*4-1:0]  TXT_OK    = {"OK", CHAR_CR, CHAR_LF};
	localparam logic [8*10-1:0] TXT_SUCC  = {":SUCCESS", CHAR_CR, CHAR_LF};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              evt_valid = 1'b0;
	logic              evt_ready;
	evt_t              evt = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	res_t              res;
	logic              cfg_we = 1'b0;
	logic              cfg_index = CFG_PEER_A;
	logic [ADDR_W-1:0] cfg_data = '0;

	// Predicted state of the relay.
	logic [2:0]        seq_ph;
	logic [6:0]        char_idx;
	logic              peer_sel;
	logic              listening;
	logic              key_lvl;
	logic [7:0]        buf_mem [0:2*MSG_LEN-1];
	logic [ADDR_W-1:0] peer_addr [0:1];

	res_t        pending_res_q [$];
	int unsigned mismatch_cnt = 0;
	int unsigned work_items = 0;
	int unsigned replies_seen = 0;
	int unsigned reply_len = 0;
	bit          reply_armed = 1'b0;
	bit          idle_on = 1'b1;
	int unsigned stall_left = 0;
	int unsigned cycle_cnt = 0;

	at_command_link_relay_core #(.MSG_LEN(MSG_LEN)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [7:0] nth_char(logic [8*22-1:0] s, int unsigned n, int unsigned k);
		return s[8*(n-1-k) +: 8];
	endfunction

	function automatic int unsigned line_len(logic [2:0] ph);
		case (ph)
			PH_CMODE: return 10;
			PH_ROLE:  return 9;
			PH_BIND:  return 22;
			PH_LINK:  return 22;
			PH_MSG:   return MSG_LEN;
			default:  return 7;
		endcase
	endfunction

	// LINK carries the address as 4, 2 and 6 hex digits with commas between.
	function automatic logic [7:0] link_byte(int unsigned pos);
		logic [ADDR_W-1:0] addr;
		int unsigned digit;
		addr = peer_addr[peer_sel];
		if (pos < 8) return nth_char(TXT_LINK, 8, pos);
		if (pos == 12 || pos == 15) return CHAR_COMMA;
		if (pos < 12) digit = pos - 8;
		else if (pos < 15) digit = pos - 9;
		else digit = pos - 10;
		if (digit > 11) return 8'h00;
		return nth_char(TXT_HEX, 16, addr[4*(11-digit) +: 4]);
	endfunction

	function automatic logic [7:0] line_byte(logic [2:0] ph, int unsigned pos);
		case (ph)
			PH_CMODE: return nth_char(TXT_CMODE, 10, pos);
			PH_ROLE:  return nth_char(TXT_ROLE, 9, pos);
			PH_BIND:  return nth_char(TXT_BIND, 22, pos);
			PH_LINK:  return link_byte(pos);
			PH_MSG:   return buf_mem[(peer_sel ? MSG_LEN : 0) + pos];
			default:  return nth_char(TXT_DISC, 7, pos);
		endcase
	endfunction

	function automatic logic [7:0] reply_pat_byte(logic [2:0] ph, int unsigned idx);
		if (ph == PH_DISC) return (idx < 10) ? nth_char(TXT_SUCC, 10, idx) : 8'h00;
		return (idx < 4) ? nth_char(TXT_OK, 4, idx) : 8'h00;
	endfunction

	// A byte moves the matcher forward at most one place.
	function automatic bit pattern_hit(int unsigned n, logic [7:0] b);
		bit hit;
		hit = 1'b0;
		if (char_idx < n && b == reply_pat_byte(seq_ph, char_idx)) begin
			if (char_idx == n - 1) begin
				char_idx = '0;
				hit = 1'b1;
			end else begin
				char_idx = char_idx + 7'd1;
			end
		end
		return hit;
	endfunction

	task automatic relay_reset_state();
		seq_ph = PH_CMODE;
		char_idx = '0;
		peer_sel = 1'b0;
		listening = 1'b0;
		key_lvl = 1'b1;
		peer_addr[0] = PEER_A_RESET;
		peer_addr[1] = PEER_B_RESET;
		for (int i = 0; i < 2*MSG_LEN; i++) buf_mem[i] = 8'h00;
		for (int i = 0; i < 4; i++) begin
			buf_mem[i] = nth_char("HOLA", 4, i);
			buf_mem[MSG_LEN + i] = nth_char("HOLA", 4, i);
		end
	endtask

	task automatic relay_predict(input evt_t e, output res_t r);
		int unsigned clen;
		int unsigned save_base;
		int unsigned sent_base;
		r = '0;
		if (!e.mode && !listening) begin
			if (seq_ph <= PH_DISC) begin
				clen = line_len(seq_ph);
				if (seq_ph == PH_MSG) key_lvl = 1'b0;
				if (seq_ph == PH_DISC) key_lvl = 1'b1;
				if (char_idx < clen) begin
					r.tx_valid = 1'b1;
					r.tx_byte = line_byte(seq_ph, char_idx);
					char_idx = char_idx + 7'd1;
				end else if (char_idx == clen) begin
					r.tx_valid = 1'b1;
					r.tx_byte = CHAR_CR;
					char_idx = char_idx + 7'd1;
				end else if (char_idx == clen + 1) begin
					r.tx_valid = 1'b1;
					r.tx_byte = CHAR_LF;
					char_idx = char_idx + 7'd1;
				end else begin
					char_idx = '0;
					listening = 1'b1;
				end
			end else begin
				r.tx_valid = 1'b1;
				r.tx_byte = 8'h00;
				listening = 1'b1;
			end
		end else if (e.mode && listening) begin
			if (seq_ph <= PH_LINK) begin
				if (pattern_hit(4, e.rx_byte)) begin
					seq_ph = seq_ph + 3'd1;
					listening = 1'b0;
				end
			end else if (seq_ph == PH_MSG) begin
				save_base = peer_sel ? 0 : MSG_LEN;
				sent_base = peer_sel ? MSG_LEN : 0;
				if (e.rx_byte == CHAR_LF || char_idx >= MSG_LEN) begin
					char_idx = '0;
					seq_ph = PH_DISC;
					listening = 1'b0;
				end else begin
					buf_mem[save_base + char_idx] = e.rx_byte;
					char_idx = char_idx + 7'd1;
				end
				for (int i = 0; i < MSG_LEN; i++) buf_mem[sent_base + i] = 8'h00;
			end else if (seq_ph == PH_DISC) begin
				if (pattern_hit(10, e.rx_byte)) begin
					seq_ph = PH_LINK;
					peer_sel = ~peer_sel;
					listening = 1'b0;
				end
			end
		end
		r.receive_mode = listening;
		r.key_pin = key_lvl;
		r.phase = seq_ph;
		r.peer_select = peer_sel;
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (mismatch_cnt < 40) begin
			$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		end
		mismatch_cnt++;
	endtask

	task automatic pause(input int unsigned n);
		evt_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_evt(input evt_t e);
		res_t r;
		evt <= e;
		evt_valid <= 1'b1;
		do @(posedge clk); while (!evt_ready);
		relay_predict(e, r);
		pending_res_q.push_back(r);
		if (idle_on && $urandom_range(0, 5) == 0) pause($urandom_range(1, 14));
	endtask

	function automatic evt_t rx_evt(logic [7:0] b);
		evt_t e;
		e.mode = 1'b1;
		e.rx_byte = b;
		return e;
	endfunction

	function automatic evt_t ready_evt();
		evt_t e;
		e.mode = 1'b0;
		e.rx_byte = 8'($urandom_range(0, 255));
		return e;
	endfunction

	// Holds the sender until every outstanding result has been taken.
	task automatic drain();
		evt_valid <= 1'b0;
		while (pending_res_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_peers(input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] b);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PEER_A;
		cfg_data <= a;
		@(posedge clk);
		peer_addr[0] = a;
		cfg_index <= CFG_PEER_B;
		cfg_data <= b;
		@(posedge clk);
		peer_addr[1] = b;
		cfg_we <= 1'b0;
	endtask

	task automatic test_wrong_direction();
		send_evt(rx_evt(8'h00));
		send_evt(rx_evt(8'hFF));
	endtask

	// CMODE line, then an OK reply with repeated letters and noise mixed in.
	task automatic test_cmode_reply();
		repeat (13) send_evt(ready_evt());
		send_evt(ready_evt());
		send_evt(rx_evt("O"));
		send_evt(rx_evt("O"));
		send_evt(rx_evt("K"));
		send_evt(rx_evt("K"));
		send_evt(rx_evt(CHAR_CR));
		send_evt(rx_evt(8'hFF));
		send_evt(rx_evt(CHAR_LF));
	endtask

	// Mostly well-formed replies with random content; noise and wrong-direction events mixed in.
	task automatic step_auto(output bit boundary);
		evt_t e;
		logic [2:0] ph0;
		bit live;
		ph0 = seq_ph;
		e.mode = 1'b1;
		e.rx_byte = 8'($urandom_range(0, 255));
		if (!listening) begin
			e.mode = ($urandom_range(0, 15) == 0);
		end else if (seq_ph == PH_MSG) begin
			if (!reply_armed) begin
				reply_armed = 1'b1;
				if (replies_seen == 0) reply_len = MSG_LEN;
				else if (replies_seen == 1) reply_len = 0;
				else if ($urandom_range(0, 4) == 0) reply_len = MSG_LEN;
				else reply_len = $urandom_range(1, 20);
				replies_seen++;
			end
			if (char_idx >= MSG_LEN) begin
				// Any byte closes a full buffer.
			end else if (char_idx == reply_len) begin
				e.rx_byte = CHAR_LF;
			end else if (e.rx_byte == CHAR_LF) begin
				e.rx_byte = 8'hF5;
			end
		end else begin
			case ($urandom_range(0, 7))
				0: e.mode = 1'b0;
				1: if (char_idx != 0) e.rx_byte = reply_pat_byte(seq_ph, char_idx - 1);
				2: ;
				default: e.rx_byte = reply_pat_byte(seq_ph, char_idx);
			endcase
		end
		live = (e.mode == listening);
		send_evt(e);
		if (live) work_items++;
		if (seq_ph != PH_MSG) reply_armed = 1'b0;
		boundary = (ph0 == PH_DISC && seq_ph == PH_LINK);
	endtask

	task automatic test_random_sessions();
		int unsigned sess;
		bit boundary;
		bit quiet;
		sess = 0;
		quiet = 1'b0;
		while (work_items < WORK_ITEMS) begin
			if (work_items >= QUIET_FROM) begin
				quiet = 1'b1;
				idle_on = 1'b0;
			end
			step_auto(boundary);
			if (boundary) begin
				sess++;
				if (!quiet) idle_on = ($urandom_range(0, 3) != 0);
				if (sess <= 3 || $urandom_range(0, 1) == 1) begin
					drain();
					case (sess)
						1: set_peers('0, '1);
						2: set_peers('1, '0);
						3: set_peers(48'h0123_4567_89AB, 48'hFEDC_BA98_7654);
						default: set_peers(48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
					endcase
				end
			end
		end
	endtask

	// Result checking and receiver stalls.
	always @(posedge clk) begin
		res_t want;
		if (res_valid && res_ready) begin
			if (pending_res_q.size() == 0) begin
				report_mismatch("result with no transaction pending", res, 0);
			end else begin
				want = pending_res_q.pop_front();
				if (res.tx_valid !== want.tx_valid)
					report_mismatch("tx_valid", res.tx_valid, want.tx_valid);
				if (res.tx_byte !== want.tx_byte)
					report_mismatch("tx_byte", res.tx_byte, want.tx_byte);
				if (res.receive_mode !== want.receive_mode)
					report_mismatch("receive_mode", res.receive_mode, want.receive_mode);
				if (res.key_pin !== want.key_pin)
					report_mismatch("key_pin", res.key_pin, want.key_pin);
				if (res.phase !== want.phase)
					report_mismatch("phase", res.phase, want.phase);
				if (res.peer_select !== want.peer_select)
					report_mismatch("peer_select", res.peer_select, want.peer_select);
			end
		end
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 13);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("at_command_link_relay_core test failed");
		$finish;
	end

	initial begin
		relay_reset_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_wrong_direction();
		test_cmode_reply();
		test_random_sessions();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("at_command_link_relay_core test passed");
		end else begin
			$display("at_command_link_relay_core test failed");
		end
		$finish;
	end

endmodule
